FILE: rtl/opi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opi_pkg
// Types, constants and tables for the odometry pose integrator.
// ----------------------------------------------------------------------------
package opi_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_ENTRIES = 31;
  localparam int unsigned STEPS_EFF =
      (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  localparam int unsigned CW = 34;   // CORDIC datapath width
  localparam int unsigned AW = 68;   // serial product width

  localparam logic [31:0]   DPC_RESET   = 32'd1030713;
  localparam logic [CW-1:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [CW-1:0] DEG360      = 34'd23592960;
  localparam logic [CW-1:0] DEG360_X128 = 34'd3019898880;
  localparam logic [CW-1:0] DEG270      = 34'd17694720;
  localparam logic [CW-1:0] DEG180      = 34'd11796480;
  localparam logic [CW-1:0] DEG90       = 34'd5898240;

  localparam logic [2:0] REG_DPC = 3'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_TRAV,
    ST_REDUCE,
    ST_FOLD,
    ST_CSHIFT,
    ST_CUPD,
    ST_CFIN,
    ST_MUL_P,
    ST_POSE
  } state_e;

  function automatic logic [CW-1:0] atan_deg(input logic [4:0] i);
    logic [CW-1:0] v;
    case (i)
      5'd0:  v = 34'd2949120;
      5'd1:  v = 34'd1740967;
      5'd2:  v = 34'd919879;
      5'd3:  v = 34'd466945;
      5'd4:  v = 34'd234379;
      5'd5:  v = 34'd117304;
      5'd6:  v = 34'd58666;
      5'd7:  v = 34'd29335;
      5'd8:  v = 34'd14668;
      5'd9:  v = 34'd7334;
      5'd10: v = 34'd3667;
      5'd11: v = 34'd1833;
      5'd12: v = 34'd917;
      5'd13: v = 34'd458;
      5'd14: v = 34'd229;
      5'd15: v = 34'd115;
      5'd16: v = 34'd57;
      5'd17: v = 34'd29;
      5'd18: v = 34'd14;
      5'd19: v = 34'd7;
      5'd20: v = 34'd4;
      5'd21: v = 34'd2;
      5'd22: v = 34'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat52(input logic signed [51:0] v);
    logic [31:0] r;
    if (v > 52'sd2147483647) r = 32'h7fffffff;
    else if (v < -52'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat40(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) r = 32'h7fffffff;
    else if (v < -40'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/odometry_pose_integrator.sv
`default_nettype none
// Set pose: result valid in the cycle after it is accepted. Sample: 32 multiply steps, 8 reduction
// steps, CORDIC with each step's shift done serially, 34 multiply steps.
// Throughput: one item at a time; the next is taken once the result is transferred.
// Reset clears pose, heading, count, deltas and loads distance_per_count default.
// ----------------------------------------------------------------------------
// odometry_pose_integrator
// Dead-reckoning odometry with midpoint heading, serial multiply and CORDIC.
// ----------------------------------------------------------------------------
module odometry_pose_integrator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [31:0] encoder_count_i,
  input  wire logic [31:0] heading_in_i,
  input  wire logic [31:0] pose_x_in_i,
  input  wire logic [31:0] pose_y_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] pos_x_o,
  output logic      [31:0] pos_y_o,
  output logic      [31:0] heading_out_o,
  output logic      [31:0] travel_delta_o,
  output logic      [31:0] heading_delta_o
);

  localparam int unsigned CW = opi_pkg::CW;
  localparam int unsigned AW = opi_pkg::AW;

  opi_pkg::state_e state_q, state_d;

  logic [31:0] dpc_q;
  logic [31:0] pose_x_q, pose_y_q, head_q, count_q, travel_q, turn_q;
  logic        out_valid_q;
  logic [5:0]  cnt_q;
  logic [AW-1:0] acc_q, accy_q, mcand_q;
  logic [31:0] mplr_q;
  logic [31:0] mid_q;
  logic [CW-1:0] red_q, x_q, y_q, z_q, xs_q, ys_q, cx_q, cy_q;
  logic        neg_q;
  logic [4:0]  it_q, sh_q;

  logic accept, done;
  assign accept = in_valid_i && in_ready_o;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == opi_pkg::REG_DPC[0]) ? dpc_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q <= opi_pkg::DPC_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == opi_pkg::REG_DPC[0])) begin
      dpc_q <= pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= opi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    done       = 1'b0;
    case (state_q)
      opi_pkg::ST_IDLE: begin
        in_ready_o = !out_valid_q;
        if (accept) begin
          if (op_i) done = 1'b1;
          else state_d = opi_pkg::ST_MUL_T;
        end
      end
      opi_pkg::ST_MUL_T:  if (cnt_q == 6'd31) state_d = opi_pkg::ST_TRAV;
      opi_pkg::ST_TRAV:   state_d = opi_pkg::ST_REDUCE;
      opi_pkg::ST_REDUCE: if (cnt_q == 6'd0) state_d = opi_pkg::ST_FOLD;
      opi_pkg::ST_FOLD:   state_d = opi_pkg::ST_CSHIFT;
      opi_pkg::ST_CSHIFT: if (sh_q == 5'd0) state_d = opi_pkg::ST_CUPD;
      opi_pkg::ST_CUPD: begin
        if (it_q == 5'(opi_pkg::STEPS_EFF - 1)) state_d = opi_pkg::ST_CFIN;
        else state_d = opi_pkg::ST_CSHIFT;
      end
      opi_pkg::ST_CFIN:   state_d = opi_pkg::ST_MUL_P;
      opi_pkg::ST_MUL_P:  if (cnt_q == 6'(CW - 1)) state_d = opi_pkg::ST_POSE;
      opi_pkg::ST_POSE: begin
        done    = 1'b1;
        state_d = opi_pkg::ST_IDLE;
      end
      default: state_d = opi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // datapath
  logic [31:0]        diff;
  logic signed [32:0] hsum, hdif;
  logic signed [AW-1:0] nprod;
  logic signed [51:0] trav_r;
  logic [CW-1:0]      dsh, red_sub;
  logic [CW-1:0]      zf;
  logic [CW-1:0]      at;
  logic signed [AW-1:0] rx, ry;
  logic signed [39:0] sumx, sumy;

  always_comb begin
    diff    = encoder_count_i - count_q;
    hsum    = $signed({heading_in_i[31], heading_in_i}) + $signed({head_q[31], head_q});
    hdif    = $signed({heading_in_i[31], heading_in_i}) - $signed({head_q[31], head_q});
    nprod   = $signed(AW'(0) - acc_q) + $signed(AW'(32768));
    trav_r  = 52'(nprod >>> 16);
    dsh     = opi_pkg::DEG360 << cnt_q[2:0];
    red_sub = red_q - dsh;
    if (red_q >= opi_pkg::DEG270) zf = red_q - opi_pkg::DEG360;
    else if (red_q > opi_pkg::DEG90) zf = red_q - opi_pkg::DEG180;
    else zf = red_q;
    at   = opi_pkg::atan_deg(it_q);
    rx   = ($signed(acc_q) + $signed(AW'(1) << 29)) >>> 30;
    ry   = ($signed(accy_q) + $signed(AW'(1) << 29)) >>> 30;
    sumx = $signed({{8{pose_x_q[31]}}, pose_x_q}) + $signed(rx[39:0]);
    sumy = $signed({{8{pose_y_q[31]}}, pose_y_q}) + $signed(ry[39:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q <= '0;
      pose_y_q <= '0;
      head_q   <= '0;
      count_q  <= '0;
      travel_q <= '0;
      turn_q   <= '0;
    end else begin
      case (state_q)
        opi_pkg::ST_IDLE: begin
          if (accept) begin
            head_q  <= heading_in_i;
            count_q <= encoder_count_i;
            if (op_i) begin
              pose_x_q <= pose_x_in_i;
              pose_y_q <= pose_y_in_i;
            end else begin
              turn_q <= opi_pkg::sat40(40'(hdif));
            end
          end
        end
        opi_pkg::ST_TRAV: travel_q <= opi_pkg::sat52(trav_r);
        opi_pkg::ST_POSE: begin
          pose_x_q <= opi_pkg::sat40(sumx);
          pose_y_q <= opi_pkg::sat40(sumy);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      opi_pkg::ST_IDLE: begin
        acc_q   <= '0;
        mcand_q <= {{(AW-32){diff[31]}}, diff};
        mplr_q  <= dpc_q;
        mid_q   <= hsum[32:1];
        cnt_q   <= '0;
      end
      opi_pkg::ST_MUL_T: begin
        if (mplr_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q <= mcand_q << 1;
        mplr_q  <= mplr_q >> 1;
        cnt_q   <= cnt_q + 6'd1;
      end
      opi_pkg::ST_TRAV: begin
        red_q <= mid_q[31] ? ({{(CW-32){1'b1}}, mid_q} + opi_pkg::DEG360_X128)
                           : {{(CW-32){1'b0}}, mid_q};
        cnt_q <= 6'd7;
      end
      opi_pkg::ST_REDUCE: begin
        if (red_q >= dsh) red_q <= red_sub;
        cnt_q <= cnt_q - 6'd1;
      end
      opi_pkg::ST_FOLD: begin
        z_q   <= zf;
        neg_q <= (red_q < opi_pkg::DEG270) && (red_q > opi_pkg::DEG90);
        x_q   <= opi_pkg::CORDIC_GAIN;
        y_q   <= '0;
        xs_q  <= opi_pkg::CORDIC_GAIN;
        ys_q  <= '0;
        it_q  <= '0;
        sh_q  <= '0;
      end
      opi_pkg::ST_CSHIFT: begin
        if (sh_q != 5'd0) begin
          xs_q <= {xs_q[CW-1], xs_q[CW-1:1]};
          ys_q <= {ys_q[CW-1], ys_q[CW-1:1]};
          sh_q <= sh_q - 5'd1;
        end
      end
      opi_pkg::ST_CUPD: begin
        if (!z_q[CW-1]) begin
          x_q  <= x_q - ys_q;
          y_q  <= y_q + xs_q;
          z_q  <= z_q - at;
          xs_q <= x_q - ys_q;
          ys_q <= y_q + xs_q;
        end else begin
          x_q  <= x_q + ys_q;
          y_q  <= y_q - xs_q;
          z_q  <= z_q + at;
          xs_q <= x_q + ys_q;
          ys_q <= y_q - xs_q;
        end
        it_q <= it_q + 5'd1;
        sh_q <= it_q + 5'd1;
      end
      opi_pkg::ST_CFIN: begin
        cx_q    <= neg_q ? (CW'(0) - x_q) : x_q;
        cy_q    <= neg_q ? (CW'(0) - y_q) : y_q;
        acc_q   <= '0;
        accy_q  <= '0;
        mcand_q <= {{(AW-32){travel_q[31]}}, travel_q};
        cnt_q   <= '0;
      end
      opi_pkg::ST_MUL_P: begin
        if (cnt_q == 6'(CW - 1)) begin
          if (cx_q[0]) acc_q  <= acc_q - mcand_q;
          if (cy_q[0]) accy_q <= accy_q - mcand_q;
        end else begin
          if (cx_q[0]) acc_q  <= acc_q + mcand_q;
          if (cy_q[0]) accy_q <= accy_q + mcand_q;
        end
        cx_q    <= cx_q >> 1;
        cy_q    <= cy_q >> 1;
        mcand_q <= mcand_q << 1;
        cnt_q   <= cnt_q + 6'd1;
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = pose_x_q;
  assign pos_y_o         = pose_y_q;
  assign heading_out_o   = head_q;
  assign travel_delta_o  = travel_q;
  assign heading_delta_o = turn_q;

endmodule
`default_nettype wire
